@@ rtl/cicc_pkg.sv @@
// Shared types, codes and constants of the circle immersed-boundary cell classifier.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cicc_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int SQRT_STAGES    = 32;
  localparam int DIV_STAGES     = 15;
  localparam int Q214_ONE       = 16384;

  typedef enum logic [1:0] {
    KIND_FLUID = 2'd0,
    KIND_BODY  = 2'd1,
    KIND_GHOST = 2'd2
  } cell_kind_e;

  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_RADIUS       = 3'd2,
    CFG_CELL_WIDTH_X = 3'd3,
    CFG_CELL_WIDTH_Y = 3'd4,
    CFG_GHOST_X      = 3'd5,
    CFG_GHOST_Y      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic [30:0]        width_x;
    logic [30:0]        width_y;
    logic [3:0]         ghost_x;
    logic [3:0]         ghost_y;
  } geom_cfg_t;

  typedef struct packed {
    cell_kind_e  kind;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        neg_x;
    logic        neg_y;
    logic        last;
  } tag_t;

  typedef struct packed {
    cell_kind_e         kind;
    logic [30:0]        wall;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/cicc_intf.sv @@
// Channel interfaces: cell input, classification result and configuration write.
// Depends on cicc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cicc_in_if import cicc_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [IndexBits-1:0] cell_i;
  logic [IndexBits-1:0] cell_j;
  logic                 last_cell;
  modport source (output valid, cell_i, cell_j, last_cell, input ready);
  modport sink   (input valid, cell_i, cell_j, last_cell, output ready);
endinterface

interface cicc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cell_kind;
  logic [30:0]        wall_distance;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic               last_out;
  modport source (output valid, cell_kind, wall_distance, normal_x, normal_y, last_out,
                  input ready);
  modport sink   (input valid, cell_kind, wall_distance, normal_x, normal_y, last_out,
                  output ready);
endinterface

interface cicc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/cicc_geom.sv @@
// Geometry front end: cell center offsets, inside and ghost-band tests, squared distance.
// Six register stages; depends on cicc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cicc_geom import cicc_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire geom_cfg_t            cfg_i,
  input  wire logic                 valid_i,
  input  wire logic [IndexBits-1:0] cell_i_i,
  input  wire logic [IndexBits-1:0] cell_j_i,
  input  wire logic                 last_i,
  output logic                      valid_o,
  output tag_t                      tag_o,
  output logic [63:0]               sum_o
);

  localparam int PW = IndexBits + 32;
  localparam int OW = PW + 2;

  logic [5:0] vld_q;

  logic [31:0] r2;
  logic [63:0] rsq_q;
  logic [35:0] bx_q, by_q;

  assign r2 = {cfg_i.radius, 1'b0};

  always_ff @(posedge clk_i) begin
    rsq_q <= 64'(r2) * 64'(r2);
    bx_q  <= {36'(cfg_i.ghost_x) * 36'(cfg_i.width_x)} << 1;
    by_q  <= {36'(cfg_i.ghost_y) * 36'(cfg_i.width_y)} << 1;
  end

  // stage 1
  logic [PW-1:0] p1x_q, p1y_q;
  logic          l1_q;
  // stage 2
  logic [31:0] a2x_q, a2y_q;
  logic        n2x_q, n2y_q, near2_q, l2_q;
  // stage 3
  logic [31:0] a3x_q, a3y_q;
  logic [63:0] s3x_q, s3y_q;
  logic        n3x_q, n3y_q, near3_q, l3_q;
  // stage 4
  logic [31:0] a4x_q, a4y_q;
  logic [63:0] rem4x_q, rem4y_q, sum4_q;
  logic [36:0] lim4x_q, lim4y_q;
  logic        n4x_q, n4y_q, in4_q, l4_q;
  // stage 5
  logic [31:0] a5x_q, a5y_q;
  logic [63:0] rem5x_q, rem5y_q, sum5_q, sq5x_q, sq5y_q;
  logic        ov5x_q, ov5y_q, n5x_q, n5y_q, in5_q, l5_q;
  // stage 6
  tag_t        tag_q;
  logic [63:0] sum_q;

  logic signed [OW-1:0] ox, oy;
  logic [OW-1:0]        ax, ay;
  logic                 gh;
  cell_kind_e           kind;

  always_comb begin
    ox = $signed({2'b00, p1x_q}) - (OW'(cfg_i.center_x) <<< 1);
    oy = $signed({2'b00, p1y_q}) - (OW'(cfg_i.center_y) <<< 1);
    ax = ox[OW-1] ? OW'(-ox) : OW'(ox);
    ay = oy[OW-1] ? OW'(-oy) : OW'(oy);
    gh = ov5x_q || (rem5x_q < sq5x_q) || ov5y_q || (rem5y_q < sq5y_q);
    if (!in5_q) begin
      kind = KIND_FLUID;
    end else if (gh) begin
      kind = KIND_GHOST;
    end else begin
      kind = KIND_BODY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1x_q <= PW'({cell_i_i, 1'b1}) * PW'(cfg_i.width_x);
      p1y_q <= PW'({cell_j_i, 1'b1}) * PW'(cfg_i.width_y);
      l1_q  <= last_i;

      a2x_q   <= ax[31:0];
      a2y_q   <= ay[31:0];
      n2x_q   <= ox[OW-1];
      n2y_q   <= oy[OW-1];
      near2_q <= (ax < OW'(r2)) && (ay < OW'(r2));
      l2_q    <= l1_q;

      a3x_q   <= a2x_q;
      a3y_q   <= a2y_q;
      s3x_q   <= 64'(a2x_q) * 64'(a2x_q);
      s3y_q   <= 64'(a2y_q) * 64'(a2y_q);
      n3x_q   <= n2x_q;
      n3y_q   <= n2y_q;
      near3_q <= near2_q;
      l3_q    <= l2_q;

      a4x_q   <= a3x_q;
      a4y_q   <= a3y_q;
      rem4x_q <= rsq_q - s3y_q;
      rem4y_q <= rsq_q - s3x_q;
      sum4_q  <= s3x_q + s3y_q;
      lim4x_q <= 37'(a3x_q) + 37'(bx_q);
      lim4y_q <= 37'(a3y_q) + 37'(by_q);
      in4_q   <= near3_q && (s3y_q < rsq_q - s3x_q);
      n4x_q   <= n3x_q;
      n4y_q   <= n3y_q;
      l4_q    <= l3_q;

      a5x_q   <= a4x_q;
      a5y_q   <= a4y_q;
      rem5x_q <= rem4x_q;
      rem5y_q <= rem4y_q;
      sum5_q  <= sum4_q;
      sq5x_q  <= 64'(lim4x_q[31:0]) * 64'(lim4x_q[31:0]);
      sq5y_q  <= 64'(lim4y_q[31:0]) * 64'(lim4y_q[31:0]);
      ov5x_q  <= lim4x_q[36:32] != 5'd0;
      ov5y_q  <= lim4y_q[36:32] != 5'd0;
      in5_q   <= in4_q;
      n5x_q   <= n4x_q;
      n5y_q   <= n4y_q;
      l5_q    <= l4_q;

      tag_q.kind  <= kind;
      tag_q.ax    <= a5x_q;
      tag_q.ay    <= a5y_q;
      tag_q.neg_x <= n5x_q;
      tag_q.neg_y <= n5y_q;
      tag_q.last  <= l5_q;
      sum_q       <= sum5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign tag_o   = tag_q;
  assign sum_o   = sum_q;

endmodule
`default_nettype wire

@@ rtl/cicc_sqrt.sv @@
// Pipelined 64-bit integer square root, one root bit per register stage.
// Carries the cell tag alongside; depends on cicc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cicc_sqrt import cicc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire tag_t        tag_i,
  input  wire logic [63:0] sum_i,
  output logic             valid_o,
  output tag_t             tag_o,
  output logic [31:0]      root_o
);

  logic [63:0] rem_q [SQRT_STAGES];
  logic [63:0] res_q [SQRT_STAGES];
  tag_t        tag_q [SQRT_STAGES];
  logic [63:0] rem_d [SQRT_STAGES];
  logic [63:0] res_d [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vld_q;

  always_comb begin
    logic [63:0] rem_in, res_in, bitv;
    logic [64:0] trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      rem_in = (k == 0) ? sum_i : rem_q[(k == 0) ? 0 : k - 1];
      res_in = (k == 0) ? 64'd0 : res_q[(k == 0) ? 0 : k - 1];
      bitv   = 64'd1 << 6'(62 - 2 * k);
      trial  = {1'b0, res_in} + {1'b0, bitv};
      if ({1'b0, rem_in} >= trial) begin
        rem_d[k] = rem_in - trial[63:0];
        res_d[k] = (res_in >> 1) + bitv;
      end else begin
        rem_d[k] = rem_in;
        res_d[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        res_q[k] <= res_d[k];
        tag_q[k] <= (k == 0) ? tag_i : tag_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign tag_o   = tag_q[SQRT_STAGES-1];
  assign root_o  = res_q[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

@@ rtl/cicc_norm.sv @@
// Unit normal by pipelined restoring division, wall distance and result register.
// One quotient bit per division stage for both axes; depends on cicc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cicc_norm import cicc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [30:0] radius_i,
  input  wire logic        valid_i,
  input  wire tag_t        tag_i,
  input  wire logic [31:0] root_i,
  output logic             valid_o,
  output result_t          res_o
);

  localparam int NS = DIV_STAGES + 1;

  logic [47:0]           remx_q [NS];
  logic [47:0]           remy_q [NS];
  logic [DIV_STAGES-1:0] qx_q   [NS];
  logic [DIV_STAGES-1:0] qy_q   [NS];
  logic [31:0]           d_q    [NS];
  tag_t                  tag_q  [NS];
  logic [NS:0]           vld_q;
  result_t               out_q;

  logic [47:0]           remx_d [NS];
  logic [47:0]           remy_d [NS];
  logic [DIV_STAGES-1:0] qx_d   [NS];
  logic [DIV_STAGES-1:0] qy_d   [NS];

  always_comb begin
    logic [47:0] dsh;
    remx_d[0] = {1'b0, tag_i.ax, 15'd0} + 48'(root_i);
    remy_d[0] = {1'b0, tag_i.ay, 15'd0} + 48'(root_i);
    qx_d[0]   = '0;
    qy_d[0]   = '0;
    for (int k = 1; k < NS; k++) begin
      dsh       = {15'd0, d_q[k-1], 1'b0} << 4'(DIV_STAGES - k);
      remx_d[k] = remx_q[k-1];
      remy_d[k] = remy_q[k-1];
      qx_d[k]   = qx_q[k-1];
      qy_d[k]   = qy_q[k-1];
      if (remx_q[k-1] >= dsh) begin
        remx_d[k] = remx_q[k-1] - dsh;
        qx_d[k][DIV_STAGES-k] = 1'b1;
      end
      if (remy_q[k-1] >= dsh) begin
        remy_d[k] = remy_q[k-1] - dsh;
        qy_d[k][DIV_STAGES-k] = 1'b1;
      end
    end
  end

  function automatic logic signed [15:0] fmt(logic [DIV_STAGES-1:0] q, logic neg);
    logic [15:0] m;
    m = (q > DIV_STAGES'(Q214_ONE)) ? 16'(Q214_ONE) : 16'(q);
    return neg ? $signed(-m) : $signed(m);
  endfunction

  logic ghost, zero;
  assign ghost = tag_q[NS-1].kind == KIND_GHOST;
  assign zero  = !ghost || (d_q[NS-1] == 32'd0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        remx_q[k] <= remx_d[k];
        remy_q[k] <= remy_d[k];
        qx_q[k]   <= qx_d[k];
        qy_q[k]   <= qy_d[k];
        d_q[k]    <= (k == 0) ? root_i : d_q[(k == 0) ? 0 : k - 1];
        tag_q[k]  <= (k == 0) ? tag_i : tag_q[(k == 0) ? 0 : k - 1];
      end
      out_q.kind <= tag_q[NS-1].kind;
      out_q.last <= tag_q[NS-1].last;
      out_q.wall <= ghost ? radius_i - d_q[NS-1][31:1] : 31'd0;
      out_q.nx   <= zero ? 16'sd0 : fmt(qx_q[NS-1], tag_q[NS-1].neg_x);
      out_q.ny   <= zero ? 16'sd0 : fmt(qy_q[NS-1], tag_q[NS-1].neg_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS];
  assign res_o   = out_q;

endmodule
`default_nettype wire

@@ rtl/cylinder_immersed_cell_classifier_top.sv @@
// Classifies grid cells against a circle as fluid, body or ghost, one cell per clock
// cycle unless a result waits unaccepted, through 6 geometry stages, 32 square-root
// stages (one root bit each) and 17 normal stages (operand setup, 15 division stages of
// one quotient bit each, result register). The whole pipeline holds when a result waits
// unaccepted; ready on the input follows that hold alone.
// Configuration writes are always accepted and take effect for cells sent afterwards.
// Depends on cicc_pkg, cicc_intf, cicc_geom, cicc_sqrt and cicc_norm.
`timescale 1ns / 1ps
`default_nettype none
module cylinder_immersed_cell_classifier_top import cicc_pkg::*; #(
  parameter int IndexBits = INDEX_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cicc_in_if.sink   in_i,
  cicc_cfg_if.sink  cfg_i,
  cicc_out_if.source out_o
);

  geom_cfg_t cfg_q;
  logic      en;
  logic      g_vld, s_vld, n_vld;
  tag_t      g_tag, s_tag;
  logic [63:0] g_sum;
  logic [31:0] s_root;
  result_t   res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= 32'sd65536;
      cfg_q.center_y <= 32'sd65536;
      cfg_q.radius   <= 31'd32768;
      cfg_q.width_x  <= 31'd65536;
      cfg_q.width_y  <= 31'd65536;
      cfg_q.ghost_x  <= 4'd2;
      cfg_q.ghost_y  <= 4'd2;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_CENTER_X:     cfg_q.center_x <= $signed(cfg_i.data);
        CFG_CENTER_Y:     cfg_q.center_y <= $signed(cfg_i.data);
        CFG_RADIUS:       cfg_q.radius   <= cfg_i.data[30:0];
        CFG_CELL_WIDTH_X: cfg_q.width_x  <= cfg_i.data[30:0];
        CFG_CELL_WIDTH_Y: cfg_q.width_y  <= cfg_i.data[30:0];
        CFG_GHOST_X:      cfg_q.ghost_x  <= cfg_i.data[3:0];
        CFG_GHOST_Y:      cfg_q.ghost_y  <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the result register is full and stalled
  assign en         = !n_vld || out_o.ready;
  assign in_i.ready = en;

  cicc_geom #(.IndexBits(IndexBits)) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .valid_i  (in_i.valid),
    .cell_i_i (in_i.cell_i),
    .cell_j_i (in_i.cell_j),
    .last_i   (in_i.last_cell),
    .valid_o  (g_vld),
    .tag_o    (g_tag),
    .sum_o    (g_sum)
  );

  cicc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_vld),
    .tag_i   (g_tag),
    .sum_i   (g_sum),
    .valid_o (s_vld),
    .tag_o   (s_tag),
    .root_o  (s_root)
  );

  cicc_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .radius_i (cfg_q.radius),
    .valid_i  (s_vld),
    .tag_i    (s_tag),
    .root_i   (s_root),
    .valid_o  (n_vld),
    .res_o    (res)
  );

  assign out_o.valid         = n_vld;
  assign out_o.cell_kind     = res.kind;
  assign out_o.wall_distance = res.wall;
  assign out_o.normal_x      = res.nx;
  assign out_o.normal_y      = res.ny;
  assign out_o.last_out      = res.last;

endmodule
`default_nettype wire

@@ rtl/cicc_checker.sv @@
// Port-level assertions for the classifier top level, attached by bind.
// Depends on cicc_pkg and cylinder_immersed_cell_classifier_top.
`timescale 1ns / 1ps
`default_nettype none
module cicc_checker import cicc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [1:0]         kind_i,
  input wire logic [30:0]        wall_i,
  input wire logic signed [15:0] nx_i,
  input wire logic signed [15:0] ny_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free output");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i != 2'd3)
    else $error("undefined cell kind");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_GHOST |-> wall_i == 31'd0 && nx_i == 16'sd0 &&
    ny_i == 16'sd0)
    else $error("nonzero geometry on non-ghost cell");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_GHOST |-> nx_i <= 16'sd16384 && nx_i >= -16'sd16384 &&
    ny_i <= 16'sd16384 && ny_i >= -16'sd16384)
    else $error("normal out of range");

endmodule

bind cylinder_immersed_cell_classifier_top cicc_checker u_cicc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.cell_kind),
  .wall_i      (out_o.wall_distance),
  .nx_i        (out_o.normal_x),
  .ny_i        (out_o.normal_y)
);
`default_nettype wire

@@ tb/cylinder_immersed_cell_classifier_top_test.sv @@
// Testbench for cylinder_immersed_cell_classifier_top: drives cells and register writes,
// predicts each classification in exact integer geometry and checks every result transfer.
// Depends on cicc_pkg, cicc_intf and the classifier RTL.
`timescale 1ns / 1ps
module cylinder_immersed_cell_classifier_top_test;
  import cicc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic clk_i;
  logic rst_ni;
  cicc_in_if #(.IndexBits(12)) in_if ();
  cicc_cfg_if cfg_if ();
  cicc_out_if out_if ();

  cylinder_immersed_cell_classifier_top #(.IndexBits(12)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // geometry currently programmed into the block
  logic signed [31:0] geo_cx, geo_cy;
  logic [30:0]        geo_radius, geo_wx, geo_wy;
  logic [3:0]         geo_gx, geo_gy;

  result_t pending_results[$];
  int      idle_pct;
  bit      failed;
  int      quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit band_hit(longint unsigned rem, longint unsigned own,
                                  longint unsigned band);
    longint unsigned lim;
    lim = own + band;
    if (lim >= (64'd1 << 32)) return 1'b1;
    return rem < lim * lim;
  endfunction

  function automatic logic [15:0] unit_comp(longint off, longint unsigned mag,
                                            longint unsigned d);
    longint unsigned q;
    if (d == 0) return '0;
    q = (mag * (2 * Q214_ONE) + d) / (2 * d);
    if (q > Q214_ONE) q = Q214_ONE;
    return off < 0 ? -q[15:0] : q[15:0];
  endfunction

  function automatic result_t classify(logic [11:0] ci, logic [11:0] cj, logic last);
    longint          ox, oy;
    longint unsigned ax, ay, r2, rsq, sx, sy, bx, by, d;
    result_t         r;
    r = '0;
    r.kind = KIND_FLUID;
    r.last = last;
    ox = (2 * longint'(ci) + 1) * longint'(geo_wx) - 2 * longint'(geo_cx);
    oy = (2 * longint'(cj) + 1) * longint'(geo_wy) - 2 * longint'(geo_cy);
    ax = ox < 0 ? -ox : ox;
    ay = oy < 0 ? -oy : oy;
    r2 = 2 * longint'(geo_radius);
    rsq = r2 * r2;
    if (ax < r2 && ay < r2) begin
      sx = ax * ax;
      sy = ay * ay;
      if (sy < rsq - sx) begin
        bx = 2 * longint'(geo_gx) * longint'(geo_wx);
        by = 2 * longint'(geo_gy) * longint'(geo_wy);
        if (band_hit(rsq - sy, ax, bx) || band_hit(rsq - sx, ay, by)) begin
          d = root_floor(sx + sy);
          r.kind = KIND_GHOST;
          r.wall = geo_radius - 31'(d >> 1);
          r.nx = unit_comp(ox, ax, d);
          r.ny = unit_comp(oy, ay, d);
        end else begin
          r.kind = KIND_BODY;
        end
      end
    end
    return r;
  endfunction

  // sink side: random stalls
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_if.cell_kind !== e.kind) begin
          $error("cell_kind exp %0d act %0d", e.kind, out_if.cell_kind);
          failed = 1'b1;
        end
        if (out_if.wall_distance !== e.wall) begin
          $error("wall_distance exp %0d act %0d", e.wall, out_if.wall_distance);
          failed = 1'b1;
        end
        if (out_if.normal_x !== e.nx) begin
          $error("normal_x exp %0d act %0d", e.nx, out_if.normal_x);
          failed = 1'b1;
        end
        if (out_if.normal_y !== e.ny) begin
          $error("normal_y exp %0d act %0d", e.ny, out_if.normal_y);
          failed = 1'b1;
        end
        if (out_if.last_out !== e.last) begin
          $error("last_out exp %0d act %0d", e.last, out_if.last_out);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_cell(logic [11:0] ci, logic [11:0] cj, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cell_i    <= ci;
    in_if.cell_j    <= cj;
    in_if.last_cell <= last;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(classify(ci, cj, last));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_CENTER_X:     geo_cx = data;
      CFG_CENTER_Y:     geo_cy = data;
      CFG_RADIUS:       geo_radius = data[30:0];
      CFG_CELL_WIDTH_X: geo_wx = data[30:0];
      CFG_CELL_WIDTH_Y: geo_wy = data[30:0];
      CFG_GHOST_X:      geo_gx = data[3:0];
      CFG_GHOST_Y:      geo_gy = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] rad,
                           logic [31:0] wx, logic [31:0] wy, logic [31:0] gx,
                           logic [31:0] gy);
    drain();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_CELL_WIDTH_X, wx);
    write_reg(CFG_CELL_WIDTH_Y, wy);
    write_reg(CFG_GHOST_X, gx);
    write_reg(CFG_GHOST_Y, gy);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_geometry();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) send_cell(12'(i), 12'(j), (i == 2 && j == 2));
  endtask

  task automatic test_centered_cell();
    // cell 1,1 center lands exactly on the circle center
    write_all(32'h0001_8000, 32'h0001_8000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 2, 2);
    send_cell(1, 1, 1'b0);
    send_cell(0, 1, 1'b0);
    send_cell(1, 0, 1'b1);
  endtask

  task automatic test_zero_radius_and_band();
    write_all(32'h0001_8000, 32'h0001_8000, 0, 32'h0001_0000, 32'h0001_0000, 2, 2);
    send_cell(1, 1, 1'b1);
    write_all(32'h0004_0000, 32'h0004_0000, 32'h0003_0000, 32'h0001_0000,
              32'h0001_0000, 0, 0);
    for (int i = 1; i < 7; i++) send_cell(12'(i), 3, 1'b0);
  endtask

  task automatic test_extremes();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 15, 15);
    send_cell(12'hFFF, 12'hFFF, 1'b1);
    send_cell(0, 0, 1'b0);
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 15, 0);
    send_cell(12'hFFF, 0, 1'b1);
    send_cell(0, 12'hFFF, 1'b0);
    send_cell(12'h800, 12'h7FF, 1'b1);
  endtask

  task automatic test_random_geometry(int phases, int cells);
    logic [31:0] wx, wy;
    logic [11:0] ci, cj;
    for (int p = 0; p < phases; p++) begin
      wx = $urandom_range(1 << 10, 1 << 17);
      wy = (p % 3 == 0) ? wx : $urandom_range(1 << 10, 1 << 17);
      write_all(wx * $urandom_range(0, 63) + $urandom_range(0, wx - 1),
                wy * $urandom_range(0, 63) + $urandom_range(0, wy - 1),
                wx * $urandom_range(1, 30) + $urandom_range(0, wx - 1),
                wx, wy, $urandom_range(0, 15), $urandom_range(0, 15));
      for (int n = 0; n < cells; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          ci = 12'($urandom_range(0, 63));
          cj = 12'($urandom_range(0, 63));
        end else begin
          ci = 12'($urandom);
          cj = 12'($urandom);
        end
        send_cell(ci, cj, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_registers(int phases, int cells);
    for (int p = 0; p < phases; p++) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      for (int n = 0; n < cells; n++)
        send_cell(12'($urandom), 12'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    failed = 1'b0;
    idle_pct = 34;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cell_i = '0;
    in_if.cell_j = '0;
    in_if.last_cell = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_CENTER_X;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    geo_cx = 32'sh0001_0000;
    geo_cy = 32'sh0001_0000;
    geo_radius = 31'h0000_8000;
    geo_wx = 31'h0001_0000;
    geo_wy = 31'h0001_0000;
    geo_gx = 4'd2;
    geo_gy = 4'd2;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_geometry();
    test_centered_cell();
    test_zero_radius_and_band();
    test_extremes();
    test_random_geometry(6, 150);
    idle_pct = 0;
    test_random_geometry(2, 150);
    idle_pct = 34;
    test_random_registers(2, 75);
    test_random_geometry(2, 150);
    drain();

    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ cylinder_immersed_cell_classifier_top.f @@
rtl/cicc_pkg.sv
rtl/cicc_intf.sv
rtl/cicc_geom.sv
rtl/cicc_sqrt.sv
rtl/cicc_norm.sv
rtl/cylinder_immersed_cell_classifier_top.sv
rtl/cicc_checker.sv
tb/cylinder_immersed_cell_classifier_top_test.sv
